[rtl/ppe_pkg.sv]
// shared constants for the perfect power exponent block
package ppe_pkg;

	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int MAX_EXPONENT_DEF = 32;
	localparam int IN_W             = 32;
	localparam int EXP_W            = 6;
	localparam int MUL_CHUNK        = 16;

endpackage

[rtl/ppe_mul.sv]
// shared multiplier: full-width a times b, one 16-bit slice of b per cycle
module ppe_mul import ppe_pkg::*; #(
	parameter int AW = VALUE_WIDTH_DEF,
	parameter int BW = (VALUE_WIDTH_DEF - 1) / 2 + 1
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     go,
	input  logic [AW-1:0]                                            a,
	input  logic [BW-1:0]                                            b,
	output logic                                                     done,
	output logic [AW+((BW+MUL_CHUNK-1)/MUL_CHUNK)*MUL_CHUNK-1:0]     prod
);

	localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BPW = NCH * MUL_CHUNK;
	localparam int PRW = AW + BPW;
	localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

	logic               run_q;
	logic [KW-1:0]      rem_q;
	logic [AW-1:0]      a_q;
	logic [BPW-1:0]     b_q;
	logic [PRW-1:0]     prod_q;
	logic               done_q;

	logic [BPW-1:0]           b_pad;
	logic [AW-1:0]            op_a;
	logic [BPW-1:0]           op_b;
	logic [MUL_CHUNK-1:0]     chunk;
	logic [AW+MUL_CHUNK-1:0]  part;
	logic [PRW-1:0]           acc_base;
	logic [PRW-1:0]           prod_next;

	// slices go most significant first, so the running sum shifts by a constant
	assign b_pad     = BPW'(b);
	assign op_a      = run_q ? a_q : a;
	assign op_b      = run_q ? b_q : b_pad;
	assign chunk     = op_b[BPW-1 -: MUL_CHUNK];
	assign part      = op_a * chunk;
	assign acc_base  = run_q ? (prod_q << MUL_CHUNK) : '0;
	assign prod_next = acc_base + PRW'(part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			rem_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			prod_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q    <= a;
				b_q    <= b_pad << MUL_CHUNK;
				prod_q <= prod_next;
				rem_q  <= KW'(NCH - 1);
				if (NCH == 1) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				prod_q <= prod_next;
				b_q    <= b_q << MUL_CHUNK;
				rem_q  <= rem_q - 1'b1;
				if (rem_q == KW'(1)) begin
					done_q <= 1'b1;
					run_q  <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

[rtl/perfect_power_exponent_core.sv]
// top level: largest exponent p for which a signed value is an exact p-th power
//
// A beat is taken when start is high while busy is low; busy then stays high until the
// result. The answer appears on largest_exponent for exactly one cycle with done high and
// cannot be held off, and busy drops in that same cycle so the next start is taken at once.
// Exponents are tried from MAX_EXPONENT downward (even ones skipped for negative values);
// each try builds the integer root one bit at a time, about (VALUE_WIDTH-1)/p + 1 bits, and
// checks every candidate with up to p-1 passes through one shared multiplier, each pass
// working through the ceil(VALUE_WIDTH/2)-bit operand in 16-bit slices after the candidate is launched.
// Candidates that overshoot stop at the first pass that exceeds the magnitude. No clearing
// pass follows reset.
module perfect_power_exponent_core import ppe_pkg::*; #(
	parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
	parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [IN_W-1:0] signed_value,
	output logic                   busy,
	output logic                   done,
	output logic [EXP_W-1:0]       largest_exponent
);

	localparam int XW  = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;
	localparam int CW  = (VALUE_WIDTH - 1) / 2 + 1;
	localparam int BIW = $clog2(CW);
	localparam int PW  = $clog2(MAX_EXPONENT + 1);
	localparam int NCH = (CW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PRW = VALUE_WIDTH + NCH * MUL_CHUNK;
	localparam int SKW = BIW + 1 + PW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PSEL,
		ST_SEEK,
		ST_TRY,
		ST_WAIT,
		ST_PEND
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [PW-1:0]          p_q;
	logic [BIW-1:0]         sb_q;
	logic [BIW-1:0]         bit_q;
	logic [CW-1:0]          root_q;
	logic [CW-1:0]          cand_q;
	logic                   eq_q;
	logic [PW-1:0]          ecnt_q;
	logic                   done_q;
	logic [EXP_W-1:0]       exp_q;

	logic [XW-1:0]          v_ext;
	logic [VALUE_WIDTH-1:0] v;
	logic                   in_neg;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic [CW-1:0]          cand;
	logic [SKW-1:0]         seek_prod;
	logic                   seek_more;
	logic                   over;
	logic                   exact;

	logic                   mul_go;
	logic [VALUE_WIDTH-1:0] mul_a;
	logic [CW-1:0]          mul_b;
	logic                   mul_done;
	logic [PRW-1:0]         mul_prod;

	// bits above the 32-bit field read as zero; negation of the most negative value
	// gives 2^(VALUE_WIDTH-1) as an unsigned magnitude
	assign v_ext  = XW'($unsigned(signed_value));
	assign v      = v_ext[VALUE_WIDTH-1:0];
	assign in_neg = v[VALUE_WIDTH-1];
	assign in_mag = in_neg ? (~v + 1'b1) : v;

	assign cand = root_q | (CW'(1) << bit_q);

	// highest root bit for exponent p is the largest b with b*p <= VALUE_WIDTH-1;
	// it only grows as p falls, so it is carried over and stepped up
	assign seek_prod = (SKW'(sb_q) + SKW'(1)) * SKW'(p_q);
	assign seek_more = seek_prod <= SKW'(VALUE_WIDTH - 1);

	assign over  = mul_prod > PRW'(mag_q);
	assign exact = mul_prod == PRW'(mag_q);

	assign mul_go = (state_q == ST_TRY) ||
	                ((state_q == ST_WAIT) && mul_done && !over && (ecnt_q != '0));
	assign mul_a  = (state_q == ST_TRY) ? VALUE_WIDTH'(cand) : mul_prod[VALUE_WIDTH-1:0];
	assign mul_b  = (state_q == ST_TRY) ? cand : cand_q;

	ppe_mul #(
		.AW(VALUE_WIDTH),
		.BW(CW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			p_q     <= '0;
			sb_q    <= '0;
			bit_q   <= '0;
			root_q  <= '0;
			cand_q  <= '0;
			eq_q    <= 1'b0;
			ecnt_q  <= '0;
			done_q  <= 1'b0;
			exp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mag_q   <= in_mag;
						neg_q   <= in_neg;
						p_q     <= PW'(MAX_EXPONENT);
						sb_q    <= '0;
						state_q <= ST_PSEL;
					end
				end
				ST_PSEL: begin
					if (p_q == PW'(1)) begin
						exp_q   <= EXP_W'(p_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (neg_q && !p_q[0]) begin
						p_q <= p_q - 1'b1;
					end else begin
						state_q <= ST_SEEK;
					end
				end
				ST_SEEK: begin
					if (seek_more) begin
						sb_q <= sb_q + 1'b1;
					end else begin
						root_q  <= '0;
						eq_q    <= (mag_q == '0);
						bit_q   <= sb_q;
						state_q <= ST_TRY;
					end
				end
				ST_TRY: begin
					cand_q  <= cand;
					ecnt_q  <= p_q - PW'(2);
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						if (over || (ecnt_q == '0)) begin
							if (!over) begin
								root_q <= cand_q;
								eq_q   <= exact;
							end
							if (bit_q == '0) begin
								state_q <= ST_PEND;
							end else begin
								bit_q   <= bit_q - 1'b1;
								state_q <= ST_TRY;
							end
						end else begin
							ecnt_q <= ecnt_q - 1'b1;
						end
					end
				end
				ST_PEND: begin
					if (eq_q) begin
						exp_q   <= EXP_W'(p_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						p_q     <= p_q - 1'b1;
						state_q <= ST_PSEL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign largest_exponent = exp_q;

endmodule

[rtl/ppe_checker.sv]
// port-level checks for the perfect power exponent core, bound to the top level
module ppe_props import ppe_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [EXP_W-1:0] largest_exponent
);

	// a result beat frees the block in the same cycle
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high with a result beat");

	// an accepted beat keeps the block occupied
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// an idle block with nothing started stays idle and silent
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> (!busy && !done))
		else $error("activity without an accepted beat");

	// a result beat carries a known exponent
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(largest_exponent))
		else $error("unknown exponent on a result beat");

endmodule

bind perfect_power_exponent_core ppe_props u_ppe_props (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.largest_exponent(largest_exponent)
);

[test/ppe_checker.sv]
// checker for the perfect power exponent block: predicts each exponent and compares results
module ppe_checker import ppe_pkg::*; #(
	parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
	parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic signed [IN_W-1:0] signed_value,
	input  logic                   done,
	input  logic [EXP_W-1:0]       largest_exponent,
	output int                     fail_count,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [EXP_W-1:0] expected_exps[$];
	logic [IN_W-1:0]  sent_values[$];

	// -1 below, 0 equal, 1 above; stops once the power passes the limit
	function automatic int compare_power(longint unsigned base, int e, longint unsigned limit);
		longint unsigned acc;
		acc = 1;
		if (base == 0)
			return (limit == 0) ? 0 : -1;
		for (int i = 0; i < e; i++) begin
			if (acc > limit / base)
				return 1;
			acc = acc * base;
		end
		if (acc == limit)
			return 0;
		return (acc < limit) ? -1 : 1;
	endfunction

	function automatic bit is_exact_root(longint unsigned mag, int e);
		longint unsigned root;
		longint unsigned cand;
		root = 0;
		if (e == 1)
			return 1'b1;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (compare_power(cand, e, mag) <= 0)
				root = cand;
		end
		return compare_power(root, e, mag) == 0;
	endfunction

	function automatic logic [EXP_W-1:0] predict_exponent(logic [IN_W-1:0] raw);
		longint unsigned mask;
		longint unsigned v;
		longint unsigned mag;
		bit              neg;
		int              answer;
		mask   = {64{1'b1}} >> (64 - VALUE_WIDTH);
		v      = 64'(raw) & mask;
		neg    = v[VALUE_WIDTH-1];
		mag    = neg ? ((~v + 64'd1) & mask) : v;
		answer = 1;
		// most negative value: magnitude is exactly 2^(VALUE_WIDTH-1)
		if (neg && mag == 0)
			mag = 64'd1 << (VALUE_WIDTH - 1);
		for (int p = MAX_EXPONENT; p >= 1; p--) begin
			if (neg && (p % 2) == 0)
				continue;
			if (is_exact_root(mag, p)) begin
				answer = p;
				break;
			end
		end
		return EXP_W'(answer);
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [EXP_W-1:0] want;
		logic [IN_W-1:0]  val;
		if (!arst_n) begin
			expected_exps.delete();
			sent_values.delete();
		end else begin
			if (start && !busy) begin
				expected_exps = {expected_exps, predict_exponent(signed_value)};
				sent_values   = {sent_values, signed_value};
			end
			if (done) begin
				if (expected_exps.size() == 0) begin
					report_mismatch($sformatf("result %0d with no beat outstanding",
						largest_exponent));
				end else begin
					want = expected_exps.pop_front();
					val  = sent_values.pop_front();
					if (largest_exponent !== want)
						report_mismatch($sformatf("value %0d: largest_exponent %0d, want %0d",
							$signed(val), largest_exponent, want));
				end
			end
		end
		outstanding = expected_exps.size();
	end

endmodule

[test/perfect_power_exponent_core_tb.sv]
// testbench top for the perfect power exponent block: stimulus, watchdog and verdict
module perfect_power_exponent_core_tb import ppe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_WIDTH  = 32;
	localparam int MAX_EXPONENT = 32;
	localparam int RANDOM_BEATS = 850;
	localparam int DRAIN_CYCLES = 100;
	localparam longint CYCLE_LIMIT = 12_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic signed [IN_W-1:0] signed_value;
	logic                   busy;
	logic                   done;
	logic [EXP_W-1:0]       largest_exponent;
	int                     fail_count;
	int                     outstanding;
	longint                 cycle_count;

	perfect_power_exponent_core #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_EXPONENT(MAX_EXPONENT)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.signed_value    (signed_value),
		.busy            (busy),
		.done            (done),
		.largest_exponent(largest_exponent)
	);

	ppe_checker #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_EXPONENT(MAX_EXPONENT)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.signed_value    (signed_value),
		.done            (done),
		.largest_exponent(largest_exponent),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// drive one beat after a gap and hold it until the block takes it
	task automatic send_beat(logic [IN_W-1:0] v, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		signed_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		logic [IN_W-1:0] directed[$];
		longint          pw;
		int              p;
		int              base_bits;
		int              base;
		int              burst_left;
		int              gap;
		logic [IN_W-1:0] v;

		arst_n       = 1'b0;
		start        = 1'b0;
		signed_value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, one, minus one, extremes and known powers of both signs
		directed = '{32'd0, 32'd1, -32'sd1, 32'h7fff_ffff, 32'h8000_0000,
			32'd2, -32'sd2, 32'd36, -32'sd36, -32'sd27, 32'd64, -32'sd64,
			32'd15625, -32'sd15625, 32'd65536, 32'd536870912, -32'sd536870912,
			32'd1073741824, -32'sd1073741824, 32'd1162261467, -32'sd1162261467,
			32'd1977326743, 32'd1220703125, 32'd2147395600, 32'd2146689000};
		foreach (directed[i])
			send_beat(directed[i], (i % 3 == 0) ? $urandom_range(0, 30) : 0);

		burst_left = 0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					// exact power with random base, sign and exponent
					p         = $urandom_range(2, 31);
					base_bits = 31 / p;
					base      = $urandom_range(0, (1 << base_bits) - 1);
					pw        = 1;
					for (int k = 0; k < p; k++)
						pw = pw * base;
					v = IN_W'(pw);
					if ($urandom_range(0, 1))
						v = -v;
				end
				8, 9, 10: begin
					// near a square or a cube: off by at most one
					p  = $urandom_range(2, 3);
					base = (p == 2) ? $urandom_range(2, 46340) : $urandom_range(2, 1290);
					pw = 1;
					for (int k = 0; k < p; k++)
						pw = pw * base;
					v = IN_W'(pw + $urandom_range(0, 2) - 1);
					if ($urandom_range(0, 1))
						v = -v;
				end
				11, 12, 13: v = IN_W'($urandom_range(0, 2000)) - 32'd1000;
				default: v = $urandom;
			endcase
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				case ($urandom_range(0, 9))
					0:       gap = $urandom_range(200, 2500);
					1, 2:    gap = 0;
					default: gap = $urandom_range(1, 40);
				endcase
			end else begin
				gap = 0;
			end
			burst_left--;
			send_beat(v, gap);
		end
		start <= 1'b0;
		// let the checker count the last accepted beat before watching the count
		@(posedge clk);

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
